>>> rtl/atan2_pa_pkg.sv
// Shared types and constants for the fixed-point atan2 approximation unit.
package atan2_pa_pkg;

  localparam int ANGLE_W = 16;

  localparam logic [14:0] COEF_N1     = 15'd31863;
  localparam logic [12:0] COEF_N2_MAG = 13'd6290;

  localparam logic signed [ANGLE_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [ANGLE_W-1:0] HALF_PI_Q13 = 16'sd12868;

  typedef struct packed {
    logic x_zero;
    logic y_zero;
    logic x_neg;
    logic y_neg;
    logic swapped;
  } ctrl_t;

endpackage

>>> rtl/atan2_polynomial_approx_unit.sv
// Pipelined atan2 approximation: restoring divider followed by a cubic polynomial.
// Request path: stage 1, stage 2, divider stages, polynomial stages, then the done register.
// Throughput: one request per cycle; the divider retires one quotient bit per stage.
// Each pipeline stage carries its own valid bit, so requests flow without gaps.
// Synchronous reset clears every valid bit and holds busy high while rst is asserted.
// The receiver cannot stall; each result is presented with done for one cycle.
module atan2_polynomial_approx_unit
  import atan2_pa_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] y_value,
  input  logic signed [DATA_WIDTH-1:0] x_value,
  output logic                         done,
  output logic signed [ANGLE_W-1:0]    angle
);

  localparam int W       = DATA_WIDTH;
  localparam int F       = DATA_WIDTH - 1;
  localparam int LATENCY = DATA_WIDTH + 5;

  assign busy = rst;

  // Stage 1: magnitudes and sign flags.
  logic         s1_vld;
  logic [W-1:0] s1_ax;
  logic [W-1:0] s1_ay;
  ctrl_t        s1_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_ax <= x_value[W-1] ? ($unsigned(~x_value) + 1'b1) : $unsigned(x_value);
    s1_ay <= y_value[W-1] ? ($unsigned(~y_value) + 1'b1) : $unsigned(y_value);
    s1_ctrl.x_zero  <= (x_value == '0);
    s1_ctrl.y_zero  <= (y_value == '0);
    s1_ctrl.x_neg   <= x_value[W-1];
    s1_ctrl.y_neg   <= y_value[W-1];
    s1_ctrl.swapped <= 1'b0;
  end

  // Stage 2 and divider stages: the smaller magnitude is divided by the larger one.
  logic         div_vld  [0:F];
  logic [W-1:0] div_rem  [0:F];
  logic [W-1:0] div_den  [0:F];
  logic [F-1:0] div_quo  [0:F];
  ctrl_t        div_ctrl [0:F];

  logic swap;
  assign swap = (s1_ax < s1_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld[0] <= 1'b0;
    end else begin
      div_vld[0] <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    div_rem[0]  <= swap ? s1_ax : s1_ay;
    div_den[0]  <= swap ? s1_ay : s1_ax;
    div_quo[0]  <= '0;
    div_ctrl[0] <= '{x_zero:  s1_ctrl.x_zero,
                     y_zero:  s1_ctrl.y_zero,
                     x_neg:   s1_ctrl.x_neg,
                     y_neg:   s1_ctrl.y_neg,
                     swapped: swap};
  end

  for (genvar k = 0; k < F; k++) begin : g_div
    logic [W:0] shifted;
    logic [W:0] diff;
    logic       fits;

    assign shifted = {div_rem[k], 1'b0};
    assign diff    = shifted - {1'b0, div_den[k]};
    assign fits    = (shifted >= {1'b0, div_den[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        div_vld[k+1] <= 1'b0;
      end else begin
        div_vld[k+1] <= div_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      div_rem[k+1]  <= fits ? diff[W-1:0] : shifted[W-1:0];
      div_den[k+1]  <= div_den[k];
      div_quo[k+1]  <= {div_quo[k][F-2:0], fits};
      div_ctrl[k+1] <= div_ctrl[k];
    end
  end

  // Polynomial stages.
  logic         m1_vld;
  logic [F-1:0] m1_z;
  logic [F-1:0] m1_z2;
  ctrl_t        m1_ctrl;

  logic         m2_vld;
  logic [F-1:0] m2_z;
  logic [14:0]  m2_c;
  ctrl_t        m2_ctrl;

  logic          m3_vld;
  logic [F+14:0] m3_pc;
  ctrl_t         m3_ctrl;

  logic [2*F-1:0] sq;
  logic [F+12:0]  n2_prod;
  logic [F+15:0]  rounded;
  logic [13:0]    p_mag;
  logic signed [ANGLE_W-1:0] p_signed;
  logic signed [ANGLE_W-1:0] angle_next;

  assign sq      = div_quo[F] * div_quo[F];
  assign n2_prod = COEF_N2_MAG * m1_z2;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      m3_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      m1_vld <= div_vld[F];
      m2_vld <= m1_vld;
      m3_vld <= m2_vld;
      done   <= m3_vld;
    end
  end

  always_ff @(posedge clk) begin
    m1_z    <= div_quo[F];
    m1_z2   <= sq[2*F-1:F];
    m1_ctrl <= div_ctrl[F];
    m2_z    <= m1_z;
    m2_c    <= COEF_N1 - {2'b00, n2_prod[F+12:F]};
    m2_ctrl <= m1_ctrl;
    m3_pc   <= m2_c * m2_z;
    m3_ctrl <= m2_ctrl;
    angle   <= angle_next;
  end

  always_comb begin
    rounded  = {1'b0, m3_pc} + ((F+16)'(1) << (F + 1));
    p_mag    = rounded[F+15:F+2];
    p_signed = $signed({2'b00, p_mag});
    if (m3_ctrl.x_neg ^ m3_ctrl.y_neg) begin
      p_signed = -p_signed;
    end
    if (m3_ctrl.x_zero) begin
      if (m3_ctrl.y_zero) begin
        angle_next = '0;
      end else if (m3_ctrl.y_neg) begin
        angle_next = -HALF_PI_Q13;
      end else begin
        angle_next = HALF_PI_Q13;
      end
    end else if (m3_ctrl.swapped) begin
      angle_next = (m3_ctrl.y_neg ? -HALF_PI_Q13 : HALF_PI_Q13) - p_signed;
    end else if (m3_ctrl.x_neg) begin
      angle_next = (m3_ctrl.y_neg ? -PI_Q13 : PI_Q13) + p_signed;
    end else begin
      angle_next = p_signed;
    end
  end

  // Every accepted request raises done once it has passed through the whole pipeline.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result strobe missing at the expected latency");

  // Results always lie within plus or minus pi.
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle <= PI_Q13) && (angle >= -PI_Q13))
    else $error("angle outside of plus or minus pi");

  // A zero pair yields a zero angle.
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (m3_vld && m3_ctrl.x_zero && m3_ctrl.y_zero) |=> (angle == '0))
    else $error("zero input did not give a zero angle");

  // The quotient never exceeds one, so the polynomial magnitude stays below pi/4 plus rounding.
  a_poly: assert property (@(posedge clk) disable iff (rst)
    m3_vld |-> (p_mag <= 14'd8192))
    else $error("polynomial magnitude out of range");

endmodule

>>> dv/atan2_polynomial_approx_unit_checker.sv
// Checker for the atan2 approximation unit: predicts every angle and compares it on done.
module atan2_polynomial_approx_unit_checker
  import atan2_pa_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] y_value,
  input  logic signed [DATA_WIDTH-1:0] x_value,
  input  logic                         done,
  input  logic signed [ANGLE_W-1:0]    angle,
  output int                           errors,
  output int                           pending,
  output int                           requests,
  output int                           results,
  output int                           axis_cases,
  output int                           steep_cases,
  output int                           unit_cases,
  output int                           left_cases
);

  localparam int FRAC = DATA_WIDTH - 1;
  localparam longint unsigned Z_MAX = (64'd1 << FRAC) - 64'd1;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] y;
    logic signed [DATA_WIDTH-1:0] x;
    logic signed [ANGLE_W-1:0]    angle;
  } angle_due_t;

  angle_due_t angle_due_q[$];
  int n_mismatch, n_requests, n_results, n_axis, n_steep, n_unit, n_left;

  function automatic longint signed_poly(input longint num, input longint den);
    longint unsigned num_mag, den_mag, z, z_sq, factor, mag;
    logic flip;
    flip = (num < 0) != (den < 0);
    num_mag = (num < 0) ? -num : num;
    den_mag = (den < 0) ? -den : den;
    z = (num_mag << FRAC) / den_mag;
    if (z > Z_MAX) begin
      z = Z_MAX;
    end
    z_sq = (z * z) >> FRAC;
    factor = longint'(COEF_N1) - ((longint'(COEF_N2_MAG) * z_sq) >> FRAC);
    mag = (factor * z + (64'd1 << (FRAC + 1))) >> (FRAC + 2);
    if (z == 0) begin
      flip = 1'b0;
    end
    return flip ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [ANGLE_W-1:0] predict_angle(
    input logic signed [DATA_WIDTH-1:0] y,
    input logic signed [DATA_WIDTH-1:0] x
  );
    longint yl, xl, ay, ax, res;
    yl = y;
    xl = x;
    ay = (yl < 0) ? -yl : yl;
    ax = (xl < 0) ? -xl : xl;
    if (xl == 0) begin
      res = (yl > 0) ? longint'(HALF_PI_Q13) : (yl < 0) ? -longint'(HALF_PI_Q13) : 0;
    end else if (ax >= ay) begin
      res = signed_poly(yl, xl);
      if (xl < 0) begin
        res = res + ((yl < 0) ? -longint'(PI_Q13) : longint'(PI_Q13));
      end
    end else begin
      res = ((yl < 0) ? -longint'(HALF_PI_Q13) : longint'(HALF_PI_Q13)) - signed_poly(xl, yl);
    end
    return res[ANGLE_W-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    angle_due_t head;
    angle_due_t fresh;
    int ay, ax;
    if (rst) begin
      angle_due_q.delete();
    end else begin
      if (done) begin
        n_results++;
        if (angle_due_q.size() == 0) begin
          report_mismatch($sformatf("angle %0d with no request waiting", angle));
        end else begin
          head = angle_due_q.pop_front();
          if (angle !== head.angle) begin
            report_mismatch($sformatf("y=%0d x=%0d: angle %0d, expected %0d",
                                      head.y, head.x, angle, head.angle));
          end
        end
      end
      if (start && !busy) begin
        fresh.y = y_value;
        fresh.x = x_value;
        fresh.angle = predict_angle(y_value, x_value);
        angle_due_q.push_back(fresh);
        n_requests++;
        ay = (y_value < 0) ? -int'(y_value) : int'(y_value);
        ax = (x_value < 0) ? -int'(x_value) : int'(x_value);
        if (ax == 0) n_axis++;
        else if (ay > ax) n_steep++;
        if (ax != 0 && ax == ay) n_unit++;
        if (x_value < 0) n_left++;
      end
    end
    errors      <= n_mismatch;
    pending     <= angle_due_q.size();
    requests    <= n_requests;
    results     <= n_results;
    axis_cases  <= n_axis;
    steep_cases <= n_steep;
    unit_cases  <= n_unit;
    left_cases  <= n_left;
  end

endmodule

>>> dv/atan2_polynomial_approx_unit_tb.sv
// Testbench top for the atan2 approximation unit: drives requests and gives the verdict.
module atan2_polynomial_approx_unit_tb
  import atan2_pa_pkg::*;
();

  localparam int DW = 16;
  localparam int LATENCY = DW + 5;
  localparam int RANDOM_REQUESTS = 800;
  localparam int QUIET_LIMIT = 1000;
  localparam int IDLE_PCT = 27;
  localparam logic signed [DW-1:0] MAX_POS = 16'sh7fff;
  localparam logic signed [DW-1:0] MIN_NEG = 16'sh8000;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [DW-1:0]      y_value;
  logic signed [DW-1:0]      x_value;
  logic                      done;
  logic signed [ANGLE_W-1:0] angle;
  int errors, pending, requests, results;
  int axis_cases, steep_cases, unit_cases, left_cases;
  bit idling_on;

  atan2_polynomial_approx_unit #(.DATA_WIDTH(DW)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .y_value(y_value), .x_value(x_value), .done(done), .angle(angle)
  );

  atan2_polynomial_approx_unit_checker #(.DATA_WIDTH(DW)) chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .y_value(y_value), .x_value(x_value), .done(done), .angle(angle),
    .errors(errors), .pending(pending), .requests(requests), .results(results),
    .axis_cases(axis_cases), .steep_cases(steep_cases),
    .unit_cases(unit_cases), .left_cases(left_cases)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic send_request(input logic signed [DW-1:0] y, input logic signed [DW-1:0] x);
    while (idling_on && $urandom_range(99) < IDLE_PCT) begin
      start <= 1'b0;
      y_value <= DW'($urandom);
      x_value <= DW'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    y_value <= y;
    x_value <= x;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic signed [DW-1:0] corner_value();
    case ($urandom_range(5))
      0: return MIN_NEG;
      1: return MIN_NEG + 16'sd1;
      2: return -16'sd1;
      3: return '0;
      4: return 16'sd1;
      default: return MAX_POS;
    endcase
  endfunction

  task automatic pick_random(output logic signed [DW-1:0] y, output logic signed [DW-1:0] x);
    int kind, ax, ay;
    kind = $urandom_range(99);
    if (kind < 40) begin
      y = DW'($urandom);
      x = DW'($urandom);
    end else if (kind < 60) begin
      x = DW'($urandom);
      ax = (x < 0) ? -int'(x) : int'(x);
      ay = ax + int'($urandom_range(4)) - 2;
      if (ay < 0) ay = 0;
      if (ay > 32768) ay = 32768;
      if ($urandom_range(1) == 1) y = DW'(-ay);
      else y = DW'((ay > 32767) ? 32767 : ay);
      if ($urandom_range(1) == 1) begin
        y = x;
        x = (ay > 32767) ? ((y < 0) ? MIN_NEG : MAX_POS) : DW'((y < 0) ? -ay : ay);
      end
    end else if (kind < 75) begin
      y = DW'(int'($urandom_range(32)) - 16);
      x = DW'(int'($urandom_range(32)) - 16);
    end else if (kind < 85) begin
      if ($urandom_range(1) == 1) begin
        y = '0;
        x = DW'($urandom);
      end else begin
        y = DW'($urandom);
        x = '0;
      end
    end else begin
      y = corner_value();
      x = corner_value();
    end
  endtask

  initial begin : stimulus
    int k;
    logic signed [DW-1:0] ry, rx;
    rst = 1'b1;
    start = 1'b0;
    y_value = '0;
    x_value = '0;
    idling_on = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_request(16'sd0, 16'sd0);
    send_request(16'sd1, 16'sd0);
    send_request(-16'sd1, 16'sd0);
    send_request(MAX_POS, 16'sd0);
    send_request(MIN_NEG, 16'sd0);
    send_request(16'sd0, -16'sd1);
    send_request(16'sd0, MIN_NEG);
    send_request(16'sd0, MAX_POS);
    send_request(MAX_POS, MAX_POS);
    send_request(MIN_NEG, MIN_NEG);
    send_request(MAX_POS, -MAX_POS);
    send_request(MIN_NEG, MAX_POS);
    send_request(MAX_POS, MIN_NEG);
    send_request(-16'sd5, 16'sd5);
    send_request(16'sd1, MAX_POS);
    send_request(MAX_POS, 16'sd1);
    send_request(-16'sd1, MIN_NEG);
    send_request(MIN_NEG, -16'sd1);
    send_request(16'sd100, -16'sd200);
    send_request(-16'sd300, 16'sd150);
    send_request(16'sd12345, -16'sd23456);
    send_request(-16'sd23456, -16'sd12345);

    for (k = 0; k < RANDOM_REQUESTS; k++) begin
      idling_on = !(k >= 300 && k < 450);
      pick_random(ry, rx);
      send_request(ry, rx);
    end
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);

    $display("Checked %0d angles for %0d requests; %0d on the y axis, %0d steep,",
             results, requests, axis_cases, steep_cases);
    $display("%0d with equal magnitudes and %0d with x negative; %0d never arrived.",
             unit_cases, left_cases, pending);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) quiet = 0;
      else quiet++;
    end
    $display("Timed out after %0d cycles with nothing accepted.", QUIET_LIMIT);
    $display("FAIL");
    $finish;
  end

endmodule
